[hw/rtl/c2pq_pkg.sv]
package c2pq_pkg;

    // CORDIC vectoring setup for the heading path.
    localparam int ATAN_ITERS = 30;
    localparam int PRE_SHIFT  = 30;
    localparam int U_W        = 33;   // signed angle accumulator, 2^-32 turn units
    localparam int UC_W       = 30;   // clamped angle, one quarter turn wide

    localparam logic signed [U_W-1:0] QUARTER_MAX = U_W'((64'd1 << UC_W) - 64'd1);

    // atan(2^-i) in units of 2^-32 of a full turn, rounded to nearest
    localparam logic signed [U_W-1:0] ATAN_TURNS [0:ATAN_ITERS-1] = '{
        33'sd536870912, 33'sd316933406, 33'sd167458907, 33'sd85004756, 33'sd42667331,
        33'sd21354465,  33'sd10679838,  33'sd5340245,   33'sd2670163,  33'sd1335087,
        33'sd667544,    33'sd333772,    33'sd166886,    33'sd83443,    33'sd41722,
        33'sd20861,     33'sd10430,     33'sd5215,      33'sd2608,     33'sd1304,
        33'sd652,       33'sd326,       33'sd163,       33'sd81,       33'sd41,
        33'sd20,        33'sd10,        33'sd5,         33'sd3,        33'sd1
    };

    localparam int FIELD_W = 24;   // coordinate and magnitude field width
    localparam int HEAD_W  = 8;    // heading field width

    // Quadrant information that rides along with each word.
    typedef struct packed {
        logic x_zero;
        logic x_neg;
        logic y_neg;
        logic y_zero;
    } quad_flags_t;

endpackage

[hw/rtl/cartesian_to_polar_quantized.sv]
// Cartesian to polar converter, quantized heading.
//
// Input channel (s_): one word per vector, tdata = {coord_z, coord_y, coord_x},
// each a 24-bit two's complement value. Result channel (m_): one word per
// vector, tdata = {heading, magnitude}: magnitude = floor(sqrt(x^2+y^2+z^2)),
// heading = angle of (x, y) in units of a full turn over ANGLE_STEPS.
//
// Throughput: one word per cycle while the receiver does not stall. The magnitude
// comes from a restoring square root with one result bit per stage, the heading
// from a CORDIC vectoring chain with one rotation per stage; both run side by
// side in the same stages. A word passes stages 1 to 3, the iteration chain,
// stage M and the output register; the longer of the two chains sets its length.
//
// Reset (aresetn low, synchronous) empties the pipeline and drops all words
// in flight; s_tready is low during reset.
// When the receiver stalls, the whole pipeline holds. s_tready stays high until
// one more input word has been taken into a skid register and drops in the
// next cycle; it rises again at the edge where the parked word moves into the
// pipeline once the stall ends. Nothing is lost or repeated.
module cartesian_to_polar_quantized
    import c2pq_pkg::*;
#(
    parameter int ANGLE_STEPS = 256,
    parameter int COORD_BITS  = 24
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [3*FIELD_W-1:0] s_tdata,   // coord_x [23:0], coord_y [47:24], coord_z [71:48]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [FIELD_W+HEAD_W-1:0] m_tdata  // magnitude [23:0], heading [31:24]
);

    localparam int CB     = COORD_BITS;
    localparam int SUM_W  = 2 * CB;
    localparam int RW     = CB + 3;                       // square root remainder
    localparam int CW     = CB + 32;                      // CORDIC datapath
    localparam int NSTEP  = (CB > ATAN_ITERS) ? CB : ATAN_ITERS;
    localparam int NW     = $clog2(ANGLE_STEPS + 1);
    localparam int PW     = 32 + NW;

    localparam logic [NW-1:0] STEPS_N   = NW'(ANGLE_STEPS);
    localparam logic [NW-1:0] QUARTER_N = NW'(ANGLE_STEPS / 4);
    localparam logic [NW-1:0] HALF_N    = NW'(ANGLE_STEPS / 2);

    // ------------------------------------------------------------------
    // Global advance and input skid register
    // ------------------------------------------------------------------
    logic                 pipe_en;
    logic                 in_ready_reg;
    logic                 skid_full_reg, skid_full_next;
    logic [3*FIELD_W-1:0] skid_data_reg;
    logic                 in_fire;
    logic                 ent_valid;
    logic [3*FIELD_W-1:0] ent_data;
    logic                 out_valid_reg;

    // advance everything when the output register is free or being taken
    assign pipe_en  = !out_valid_reg || m_tready;
    assign s_tready = in_ready_reg;
    assign in_fire  = s_tvalid && in_ready_reg;

    assign ent_valid = skid_full_reg || in_fire;
    assign ent_data  = skid_full_reg ? skid_data_reg : s_tdata;

    always_comb begin
        skid_full_next = skid_full_reg;
        if (pipe_en) begin
            skid_full_next = 1'b0;          // skid word moves into stage 1
        end else if (in_fire) begin
            skid_full_next = 1'b1;          // park the word until the stall ends
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skid_full_reg <= 1'b0;
            in_ready_reg  <= 1'b0;
        end else begin
            skid_full_reg <= skid_full_next;
            in_ready_reg  <= !skid_full_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!pipe_en && in_fire) begin
            skid_data_reg <= s_tdata;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: capture raw coordinates at COORD_BITS
    // ------------------------------------------------------------------
    logic                 v1_reg;
    logic signed [CB-1:0] x1_reg, y1_reg, z1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (pipe_en) begin
            v1_reg <= ent_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            x1_reg <= signed'(CB'(ent_data[FIELD_W-1:0]));
            y1_reg <= signed'(CB'(ent_data[2*FIELD_W-1:FIELD_W]));
            z1_reg <= signed'(CB'(ent_data[3*FIELD_W-1:2*FIELD_W]));
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: absolute values and quadrant flags
    // ------------------------------------------------------------------
    logic          v2_reg;
    logic [CB-1:0] ax2_reg, ay2_reg, az2_reg;
    quad_flags_t   fl2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (pipe_en) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            ax2_reg        <= x1_reg[CB-1] ? CB'(-x1_reg) : CB'(x1_reg);
            ay2_reg        <= y1_reg[CB-1] ? CB'(-y1_reg) : CB'(y1_reg);
            az2_reg        <= z1_reg[CB-1] ? CB'(-z1_reg) : CB'(z1_reg);
            fl2_reg.x_zero <= (x1_reg == '0);
            fl2_reg.x_neg  <= x1_reg[CB-1];
            fl2_reg.y_neg  <= y1_reg[CB-1];
            fl2_reg.y_zero <= (y1_reg == '0);
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: squares, CORDIC start vector
    // ------------------------------------------------------------------
    logic                 v3_reg;
    logic [SUM_W-1:0]     sqx3_reg, sqy3_reg, sqz3_reg;
    logic signed [CW-1:0] a3_reg, b3_reg;
    quad_flags_t          fl3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (pipe_en) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            sqx3_reg <= SUM_W'(ax2_reg) * SUM_W'(ax2_reg);
            sqy3_reg <= SUM_W'(ay2_reg) * SUM_W'(ay2_reg);
            sqz3_reg <= SUM_W'(az2_reg) * SUM_W'(az2_reg);
            a3_reg   <= signed'(CW'({ax2_reg, {PRE_SHIFT{1'b0}}}));
            b3_reg   <= signed'(CW'({ay2_reg, {PRE_SHIFT{1'b0}}}));
            fl3_reg  <= fl2_reg;
        end
    end

    // ------------------------------------------------------------------
    // Iteration chain: index 0 holds the sum of squares and start vector,
    // index k+1 the state after square root step k and CORDIC step k.
    // ------------------------------------------------------------------
    logic                  it_v_reg  [0:NSTEP];
    logic [SUM_W-1:0]      it_n_reg  [0:NSTEP];
    logic [RW-1:0]         it_r_reg  [0:NSTEP];
    logic [CB-1:0]         it_q_reg  [0:NSTEP];
    logic signed [CW-1:0]  it_a_reg  [0:NSTEP];
    logic signed [CW-1:0]  it_b_reg  [0:NSTEP];
    logic signed [U_W-1:0] it_u_reg  [0:NSTEP];
    quad_flags_t           it_fl_reg [0:NSTEP];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            it_v_reg[0] <= 1'b0;
        end else if (pipe_en) begin
            it_v_reg[0] <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            it_n_reg[0]  <= sqx3_reg + sqy3_reg + sqz3_reg;
            it_r_reg[0]  <= '0;
            it_q_reg[0]  <= '0;
            it_a_reg[0]  <= a3_reg;
            it_b_reg[0]  <= b3_reg;
            it_u_reg[0]  <= '0;
            it_fl_reg[0] <= fl3_reg;
        end
    end

    for (genvar k = 0; k < NSTEP; k++) begin : g_step
        logic [SUM_W-1:0]      n_next;
        logic [RW-1:0]         r_next;
        logic [CB-1:0]         q_next;
        logic signed [CW-1:0]  a_next;
        logic signed [CW-1:0]  b_next;
        logic signed [U_W-1:0] u_next;

        if (k < CB) begin : g_sqrt
            logic [RW-1:0] r_sh;
            logic [RW-1:0] trial;

            // bring down the next two bits and try root digit 1
            assign r_sh   = {it_r_reg[k][RW-3:0], it_n_reg[k][SUM_W-1 -: 2]};
            assign trial  = RW'({it_q_reg[k], 2'b01});
            assign n_next = it_n_reg[k] << 2;

            always_comb begin
                if (r_sh >= trial) begin
                    r_next = r_sh - trial;
                    q_next = {it_q_reg[k][CB-2:0], 1'b1};
                end else begin
                    r_next = r_sh;
                    q_next = {it_q_reg[k][CB-2:0], 1'b0};
                end
            end
        end else begin : g_sqrt_hold
            assign n_next = it_n_reg[k];
            assign r_next = it_r_reg[k];
            assign q_next = it_q_reg[k];
        end

        if (k < ATAN_ITERS) begin : g_cordic
            logic signed [CW-1:0] a_sh;
            logic signed [CW-1:0] b_sh;

            assign a_sh = it_a_reg[k] >>> k;
            assign b_sh = it_b_reg[k] >>> k;

            // rotate toward the x axis; a vector already on it stops turning
            always_comb begin
                if (it_b_reg[k] == '0) begin
                    a_next = it_a_reg[k];
                    b_next = it_b_reg[k];
                    u_next = it_u_reg[k];
                end else if (!it_b_reg[k][CW-1]) begin
                    a_next = it_a_reg[k] + b_sh;
                    b_next = it_b_reg[k] - a_sh;
                    u_next = it_u_reg[k] + ATAN_TURNS[k];
                end else begin
                    a_next = it_a_reg[k] - b_sh;
                    b_next = it_b_reg[k] + a_sh;
                    u_next = it_u_reg[k] - ATAN_TURNS[k];
                end
            end
        end else begin : g_cordic_hold
            assign a_next = it_a_reg[k];
            assign b_next = it_b_reg[k];
            assign u_next = it_u_reg[k];
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                it_v_reg[k+1] <= 1'b0;
            end else if (pipe_en) begin
                it_v_reg[k+1] <= it_v_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (pipe_en) begin
                it_n_reg[k+1]  <= n_next;
                it_r_reg[k+1]  <= r_next;
                it_q_reg[k+1]  <= q_next;
                it_a_reg[k+1]  <= a_next;
                it_b_reg[k+1]  <= b_next;
                it_u_reg[k+1]  <= u_next;
                it_fl_reg[k+1] <= it_fl_reg[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage M: clamp the angle to one quarter turn and scale to steps
    // ------------------------------------------------------------------
    logic            vm_reg;
    logic [NW-1:0]   hm_reg;
    logic [CB-1:0]   rootm_reg;
    quad_flags_t     flm_reg;
    logic [UC_W-1:0] u_clamp;
    logic [PW-1:0]   u_prod;

    always_comb begin
        if (it_u_reg[NSTEP][U_W-1]) begin
            u_clamp = '0;
        end else if (it_u_reg[NSTEP] > QUARTER_MAX) begin
            u_clamp = QUARTER_MAX[UC_W-1:0];
        end else begin
            u_clamp = it_u_reg[NSTEP][UC_W-1:0];
        end
    end

    assign u_prod = PW'(u_clamp) * PW'(ANGLE_STEPS);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vm_reg <= 1'b0;
        end else if (pipe_en) begin
            vm_reg <= it_v_reg[NSTEP];
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            hm_reg    <= u_prod[PW-1:32];
            rootm_reg <= it_q_reg[NSTEP];
            flm_reg   <= it_fl_reg[NSTEP];
        end
    end

    // ------------------------------------------------------------------
    // Output stage: unfold the quadrant and register the result word
    // ------------------------------------------------------------------
    logic [NW-1:0]               head_next;
    logic [NW-1:0]               head_out_reg;
    logic [FIELD_W+HEAD_W-1:0]   m_tdata_reg;

    always_comb begin
        if (flm_reg.x_zero) begin
            head_next = flm_reg.y_neg ? (STEPS_N - QUARTER_N) : QUARTER_N;
        end else if (!flm_reg.x_neg) begin
            if (!flm_reg.y_neg) begin
                head_next = hm_reg;
            end else if (hm_reg == '0) begin
                head_next = '0;              // full turn wraps to zero
            end else begin
                head_next = STEPS_N - hm_reg;
            end
        end else begin
            if (!flm_reg.y_neg && !flm_reg.y_zero) begin
                head_next = HALF_N - hm_reg;
            end else begin
                head_next = HALF_N + hm_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            out_valid_reg <= vm_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            head_out_reg <= head_next;
            m_tdata_reg  <= {HEAD_W'(head_next), FIELD_W'(rootm_reg)};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = m_tdata_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_skid_catch: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && !pipe_en) |=> skid_full_reg)
        else $error("input word taken during a stall was not parked");

    a_skid_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (skid_full_reg && pipe_en) |=> !skid_full_reg)
        else $error("parked word not moved into the pipeline");

    a_head_range: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (head_out_reg < STEPS_N))
        else $error("heading outside the angle range");

    a_chain_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (!pipe_en && it_v_reg[NSTEP]) |=> $stable(it_q_reg[NSTEP]))
        else $error("iteration chain moved during a stall");

endmodule
